/* rtl/gda_pkg.sv */
// types, codes and constants of the gregorian date adder
package gda_pkg;

    localparam int YearW   = 14;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int AmtW    = 16;
    localparam int StatusW = 2;

    // working year wide enough for year plus amount
    localparam int WyW     = 17;
    localparam int QuotW   = 13;

    localparam int AMOUNT_BITS_DEF = 16;

    localparam logic [YearW-1:0]  YEAR_RESET  = YearW'(2017);
    localparam logic [MonthW-1:0] MONTH_RESET = MonthW'(1);
    localparam logic [DayW-1:0]   DAY_RESET   = DayW'(1);
    localparam logic [WyW-1:0]    YEAR_MAX    = WyW'(9999);

    localparam logic [MonthW-1:0] MONTH_JAN = MonthW'(1);
    localparam logic [MonthW-1:0] MONTH_FEB = MonthW'(2);
    localparam logic [MonthW-1:0] MONTH_MAR = MonthW'(3);
    localparam logic [MonthW-1:0] MONTH_DEC = MonthW'(12);
    localparam logic [DayW-1:0]   DAY_LEAP  = DayW'(29);

    // reciprocals for division by a constant, both scaled by 2^RecipShift
    localparam int            RecipShift = 19;
    localparam logic [15:0]   RECIP_100  = 16'd5243;
    localparam logic [15:0]   RECIP_12   = 16'd43691;

    typedef enum logic [1:0] {
        ACT_SET        = 2'd0,
        ACT_ADD_DAYS   = 2'd1,
        ACT_ADD_MONTHS = 2'd2,
        ACT_ADD_YEARS  = 2'd3
    } t_action;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEAP_Q,
        S_LEAP_R,
        S_SET_CHK,
        S_DAYS,
        S_MON_Q,
        S_MON_R,
        S_MON_SPILL,
        S_YR_CHK,
        S_YR_FIX,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]        action;
        logic [AmtW-1:0]   amount;
        logic [YearW-1:0]  new_year;
        logic [MonthW-1:0] new_month;
        logic [DayW-1:0]   new_day;
    } t_in_req;

    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic               leap;
        logic [StatusW-1:0] status;
    } t_out_res;

    // days in a month, any code outside 1..12 counts as a long month
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (m)
            4'd2:                 len = leap ? DayW'(29) : DayW'(28);
            4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
            default:              len = DayW'(31);
        endcase
        return len;
    endfunction

endpackage

/* rtl/gregorian_date_adder_unit.sv */
// gregorian date adder: sequencer around one shared reciprocal multiplier
//
//  channel | valid      | stall      | payload                  | direction
//  --------+------------+------------+--------------------------+----------
//  request | i_in_valid | o_in_stall | i_in_req  (t_in_req)     | in
//  result  | o_out_valid| i_out_stall| o_out_res (t_out_res)    | out
//
// a request runs through these states: set: leap check, date check, finish; add
// months: divide by 12, leap check, day spill, finish; add years: range check, then
// on no overflow leap check and 29 February fix, then finish; add days steps month
// by month and redoes the leap check (multiply by reciprocal of 100) at each new year.
// reset (synchronous, i_rst_n low) loads 1 January 2017 and empties the result.
// one request at a time; a finished result waits in the output register while
// the next request is taken, and the sequencer only holds while that register is full and stalled.
module gregorian_date_adder_unit #(
    parameter int AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gda_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gda_pkg::t_out_res o_out_res
);
    import gda_pkg::*;

    localparam int KeepBits = (AMOUNT_BITS < AmtW) ? AMOUNT_BITS : AmtW;
    localparam logic [AmtW-1:0] AMT_MASK =
        AmtW'((17'(1) << KeepBits) - 17'(1));

    t_state r_state, n_state;

    // committed date
    logic [YearW-1:0]  r_year,  n_year;
    logic [MonthW-1:0] r_month, n_month;
    logic [DayW-1:0]   r_day,   n_day;
    logic              r_leap,  n_leap;

    // working copy
    logic [WyW-1:0]    r_wy,    n_wy;
    logic [MonthW-1:0] r_wm,    n_wm;
    logic [DayW-1:0]   r_wd,    n_wd;
    logic              r_wleap, n_wleap;
    logic [WyW-1:0]    r_n,     n_n;
    logic [QuotW-1:0]  r_q,     n_q;
    t_action           r_act,   n_act;
    t_status           r_st,    n_st;
    logic [MonthW-1:0] r_sm,    n_sm;
    logic [DayW-1:0]   r_sd,    n_sd;

    logic              r_out_valid, n_out_valid;
    t_out_res          r_out_res,   n_out_res;

    logic              in_acc;
    logic              out_acc;
    logic              out_free;

    // shared multiplier
    logic [WyW-1:0]    mul_a;
    logic [15:0]       mul_c;
    logic [32:0]       mul_p;
    logic [QuotW-1:0]  mul_q;

    logic [DayW-1:0]   cur_len;
    logic [WyW-1:0]    d_sum;
    logic [WyW-1:0]    d_step;
    logic [WyW-1:0]    y_inc;
    logic [WyW-1:0]    q12;
    logic [WyW-1:0]    mrem;
    logic [WyW-1:0]    q100;
    logic [WyW-1:0]    rem100;
    logic              leap_val;
    logic              set_ok;
    logic [AmtW-1:0]   amt;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign amt      = i_in_req.amount & AMT_MASK;

    // reciprocal multiply: by 1/100 for leap years, by 1/12 for months
    always_comb begin
        mul_a = (r_state == S_MON_Q) ? r_n : r_wy;
        mul_c = (r_state == S_MON_Q) ? RECIP_12 : RECIP_100;
        mul_p = 33'(mul_a) * 33'(mul_c);
        mul_q = QuotW'(mul_p >> RecipShift);
    end

    // month step and small shift-add arithmetic
    always_comb begin
        cur_len  = month_len(r_wm, r_wleap);
        d_sum    = WyW'(r_wd) + r_n;
        d_step   = WyW'(cur_len) - WyW'(r_wd) + WyW'(1);
        y_inc    = r_wy + WyW'(1);
        q12      = WyW'({r_q, 3'b000}) + WyW'({r_q, 2'b00});
        mrem     = r_n - q12;
        q100     = WyW'({r_q, 6'b0}) + WyW'({r_q, 5'b0}) + WyW'({r_q, 2'b00});
        rem100   = r_wy - q100;
        leap_val = (r_wy[1:0] == 2'b00) && ((rem100[6:0] != 7'd0) || (r_q[1:0] == 2'b00));
        set_ok   = (r_wy <= YEAR_MAX) && (r_sm >= MONTH_JAN) && (r_sm <= MONTH_DEC)
                   && (r_sd != DayW'(0)) && (r_sd <= month_len(r_sm, r_wleap));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_action'(i_in_req.action))
                        ACT_SET:        n_state = S_LEAP_Q;
                        ACT_ADD_DAYS:   n_state = S_DAYS;
                        ACT_ADD_MONTHS: n_state = S_MON_Q;
                        default:        n_state = S_YR_CHK;
                    endcase
                end
            end
            S_LEAP_Q: n_state = S_LEAP_R;
            S_LEAP_R: begin
                case (r_act)
                    ACT_SET:        n_state = S_SET_CHK;
                    ACT_ADD_DAYS:   n_state = S_DAYS;
                    ACT_ADD_MONTHS: n_state = S_MON_SPILL;
                    default:        n_state = S_YR_FIX;
                endcase
            end
            S_SET_CHK:   n_state = S_FINISH;
            S_DAYS: begin
                if (d_sum > WyW'(cur_len)) begin
                    if (r_wm == MONTH_DEC) begin
                        n_state = (y_inc > YEAR_MAX) ? S_FINISH : S_LEAP_Q;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MON_Q:     n_state = S_MON_R;
            S_MON_R:     n_state = S_LEAP_Q;
            S_MON_SPILL: n_state = S_FINISH;
            S_YR_CHK:    n_state = (r_wy > YEAR_MAX) ? S_FINISH : S_LEAP_Q;
            S_YR_FIX:    n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_leap      = r_leap;
        n_wy        = r_wy;
        n_wm        = r_wm;
        n_wd        = r_wd;
        n_wleap     = r_wleap;
        n_n         = r_n;
        n_q         = r_q;
        n_act       = r_act;
        n_st        = r_st;
        n_sm        = r_sm;
        n_sd        = r_sd;
        n_out_valid = r_out_valid && !out_acc;
        n_out_res   = r_out_res;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act   = t_action'(i_in_req.action);
                    n_st    = ST_OK;
                    n_wm    = r_month;
                    n_wd    = r_day;
                    n_wleap = r_leap;
                    n_sm    = i_in_req.new_month;
                    n_sd    = i_in_req.new_day;
                    n_n     = WyW'(amt);
                    case (t_action'(i_in_req.action))
                        ACT_SET:        n_wy = WyW'(i_in_req.new_year);
                        ACT_ADD_MONTHS: begin
                            n_wy = WyW'(r_year);
                            n_n  = WyW'(amt) + WyW'(r_month) - WyW'(1);
                        end
                        ACT_ADD_YEARS:  n_wy = WyW'(r_year) + WyW'(amt);
                        default:        n_wy = WyW'(r_year);
                    endcase
                end
            end
            S_LEAP_Q:  n_q = mul_q;
            S_LEAP_R:  n_wleap = leap_val;
            S_SET_CHK: begin
                n_wm = r_sm;
                n_wd = r_sd;
                n_st = set_ok ? ST_OK : ST_BAD_DATE;
            end
            // one month per cycle, with a leap check in between at each new year
            S_DAYS: begin
                if (d_sum > WyW'(cur_len)) begin
                    n_n  = r_n - d_step;
                    n_wd = DAY_RESET;
                    if (r_wm == MONTH_DEC) begin
                        n_wm = MONTH_JAN;
                        n_wy = y_inc;
                        if (y_inc > YEAR_MAX) begin
                            n_st = ST_OVERFLOW;
                        end
                    end else begin
                        n_wm = r_wm + MonthW'(1);
                    end
                end else begin
                    n_wd = DayW'(d_sum);
                end
            end
            S_MON_Q: n_q = mul_q;
            S_MON_R: begin
                n_wm = MonthW'(mrem) + MonthW'(1);
                n_wy = r_wy + WyW'(r_q);
            end
            // december never spills, so the year stays put here
            S_MON_SPILL: begin
                if (r_wd > cur_len) begin
                    n_wd = r_wd - cur_len;
                    n_wm = r_wm + MonthW'(1);
                end
                if (r_wy > YEAR_MAX) begin
                    n_st = ST_OVERFLOW;
                end
            end
            S_YR_CHK: begin
                if (r_wy > YEAR_MAX) begin
                    n_st = ST_OVERFLOW;
                end
            end
            S_YR_FIX: begin
                if ((r_wm == MONTH_FEB) && (r_wd == DAY_LEAP) && !r_wleap) begin
                    n_wm = MONTH_MAR;
                    n_wd = DAY_RESET;
                end
            end
            // commit on success and load the result
            S_FINISH: begin
                if (out_free) begin
                    if (r_st == ST_OK) begin
                        n_year  = YearW'(r_wy);
                        n_month = r_wm;
                        n_day   = r_wd;
                        n_leap  = r_wleap;
                    end
                    n_out_valid      = 1'b1;
                    n_out_res.year   = n_year;
                    n_out_res.month  = n_month;
                    n_out_res.day    = n_day;
                    n_out_res.leap   = n_leap;
                    n_out_res.status = r_st;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_year      <= YEAR_RESET;
            r_month     <= MONTH_RESET;
            r_day       <= DAY_RESET;
            r_leap      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_leap      <= n_leap;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_wy      <= n_wy;
        r_wm      <= n_wm;
        r_wd      <= n_wd;
        r_wleap   <= n_wleap;
        r_n       <= n_n;
        r_q       <= n_q;
        r_act     <= n_act;
        r_st      <= n_st;
        r_sm      <= n_sm;
        r_sd      <= n_sd;
        r_out_res <= n_out_res;
    end

    // port outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
        o_out_res   = r_out_res;
    end

endmodule

/* dv/gregorian_date_adder_unit_tb.sv */
// testbench for the gregorian date adder: directed and random requests with a scoreboard
module gregorian_date_adder_unit_tb;
    import gda_pkg::*;

    // keeps its own calendar date and the queue of results still owed by the block
    class date_tracker;
        int unsigned held_year;
        int unsigned held_month;
        int unsigned held_day;
        t_out_res    dates_due[$];
        int          faults;

        function new();
            held_year  = 2017;
            held_month = 1;
            held_day   = 1;
            faults     = 0;
        endfunction

        // gregorian rule, year 0 divides by 400 so it is leap
        function bit is_leap_year(int unsigned y);
            if (y % 4 != 0) return 1'b0;
            if (y % 100 != 0) return 1'b1;
            return (y % 400 == 0);
        endfunction

        // any month code outside 1..12 is treated as long
        function int unsigned month_days(int unsigned m, int unsigned y);
            case (m)
                2:             return is_leap_year(y) ? 29 : 28;
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        endfunction

        function int outstanding();
            return dates_due.size();
        endfunction

        // work out the date after an accepted request and queue the result
        function void note_command(t_in_req r);
            int unsigned yr, mo, dy, n, total, len;
            t_status     st;
            t_out_res    res;
            yr = held_year;
            mo = held_month;
            dy = held_day;
            n  = r.amount;
            st = ST_OK;
            case (t_action'(r.action))
                ACT_SET: begin
                    if (r.new_year > YEAR_MAX || r.new_month < 1 || r.new_month > 12 ||
                        r.new_day < 1 || r.new_day > month_days(r.new_month, r.new_year)) begin
                        st = ST_BAD_DATE;
                    end else begin
                        yr = r.new_year;
                        mo = r.new_month;
                        dy = r.new_day;
                    end
                end
                ACT_ADD_DAYS: begin
                    // walk month by month until the rest fits
                    while (st == ST_OK && dy + n > month_days(mo, yr)) begin
                        n  = n - (month_days(mo, yr) - dy + 1);
                        dy = 1;
                        mo++;
                        if (mo > 12) begin
                            mo = 1;
                            yr++;
                            if (yr > YEAR_MAX) st = ST_OVERFLOW;
                        end
                    end
                    if (st == ST_OK) dy += n;
                end
                ACT_ADD_MONTHS: begin
                    total = mo - 1 + n;
                    yr    = yr + total / 12;
                    mo    = total % 12 + 1;
                    len   = month_days(mo, yr);
                    // day past the end spills into the following month
                    if (dy > len) begin
                        dy = dy - len;
                        mo++;
                        if (mo > 12) begin
                            mo = 1;
                            yr++;
                        end
                    end
                    if (yr > YEAR_MAX) st = ST_OVERFLOW;
                end
                default: begin
                    yr = yr + n;
                    if (yr > YEAR_MAX) begin
                        st = ST_OVERFLOW;
                    end else if (mo == 2 && dy == 29 && !is_leap_year(yr)) begin
                        mo = 3;
                        dy = 1;
                    end
                end
            endcase
            // failed requests leave the date untouched
            if (st == ST_OK) begin
                held_year  = yr;
                held_month = mo;
                held_day   = dy;
            end
            res.year   = YearW'(held_year);
            res.month  = MonthW'(held_month);
            res.day    = DayW'(held_day);
            res.leap   = is_leap_year(held_year);
            res.status = st;
            dates_due.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                faults++;
            end
        endfunction

        // compare one delivered result with the oldest one owed
        function void check_date(t_out_res got);
            t_out_res want;
            if (dates_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %p", $time, got);
                faults++;
                return;
            end
            want = dates_due.pop_front();
            compare_field("year", want.year, got.year);
            compare_field("month", want.month, got.month);
            compare_field("day", want.day, got.day);
            compare_field("leap", want.leap, got.leap);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_CYCLES = 4_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_req   i_in_req;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_res  o_out_res;

    logic      stall_rand;
    logic      stall_hold;
    int        idle_pct_in   = 0;
    int        stall_pct_out = 0;

    date_tracker tracker = new();

    gregorian_date_adder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign i_out_stall = stall_rand | stall_hold;

    // result side: random stall and checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_date(o_out_res);
        stall_rand <= ($urandom_range(0, 99) < stall_pct_out);
    end

    // long hold-off on the result side
    task automatic hold_results();
        stall_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        stall_hold <= 1'b0;
    endtask

    // offer one request, with random gaps, and wait for it to be taken
    task automatic send_cmd(t_in_req c);
        while ($urandom_range(0, 99) < idle_pct_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_command(c);
    endtask

    // sender pauses until every owed result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    function automatic t_in_req set_cmd(int unsigned y, int unsigned m, int unsigned d);
        t_in_req c;
        c           = '0;
        c.action    = ACT_SET;
        c.new_year  = YearW'(y);
        c.new_month = MonthW'(m);
        c.new_day   = DayW'(d);
        return c;
    endfunction

    function automatic t_in_req add_cmd(t_action a, int unsigned n);
        t_in_req c;
        c        = '0;
        c.action = a;
        c.amount = AmtW'(n);
        return c;
    endfunction

    // mostly well-formed dates and modest amounts, some raw noise and huge amounts
    function automatic t_in_req random_command();
        t_in_req     c;
        int unsigned pick, sz, len, y, m;
        c.amount    = AmtW'($urandom);
        c.new_year  = YearW'($urandom);
        c.new_month = MonthW'($urandom);
        c.new_day   = DayW'($urandom);
        pick = $urandom_range(0, 99);
        sz   = $urandom_range(0, 99);
        if (pick < 25) begin
            c.action = ACT_SET;
            if ($urandom_range(0, 3) != 0) begin
                y   = $urandom_range(0, 9999);
                m   = $urandom_range(1, 12);
                len = tracker.month_days(m, y);
                c.new_year  = YearW'(y);
                c.new_month = MonthW'(m);
                c.new_day   = DayW'($urandom_range(0, 1) ? $urandom_range(1, len)
                                                         : $urandom_range(len - 2, len));
            end
        end else if (pick < 50) begin
            c.action = ACT_ADD_DAYS;
            if (sz < 90)      c.amount = AmtW'($urandom_range(0, 400));
            else if (sz < 97) c.amount = AmtW'($urandom_range(0, 4000));
        end else if (pick < 75) begin
            c.action = ACT_ADD_MONTHS;
            if (sz < 85)      c.amount = AmtW'($urandom_range(0, 30));
            else if (sz < 95) c.amount = AmtW'($urandom_range(0, 1000));
        end else begin
            c.action = ACT_ADD_YEARS;
            if (sz < 85)      c.amount = AmtW'($urandom_range(0, 50));
            else if (sz < 95) c.amount = AmtW'($urandom_range(0, 500));
        end
        return c;
    endfunction

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        idle_pct_in   = idle_pct;
        stall_pct_out = stall_pct;
        repeat (count) send_cmd(random_command());
        wait_drained();
    endtask

    // run limit
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        stall_rand = 1'b0;
        stall_hold = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero amounts, invalid sets, spills, leap moves, overflows
        send_cmd(add_cmd(ACT_ADD_DAYS, 0));
        send_cmd(set_cmd(2000, 2, 29));
        send_cmd(add_cmd(ACT_ADD_YEARS, 1));
        send_cmd(set_cmd(1900, 2, 29));
        send_cmd(set_cmd(2017, 0, 10));
        send_cmd(set_cmd(16383, 15, 31));
        send_cmd(set_cmd(2017, 4, 31));
        send_cmd(set_cmd(2017, 5, 0));
        send_cmd(set_cmd(10000, 1, 1));
        send_cmd(set_cmd(0, 1, 31));
        send_cmd(add_cmd(ACT_ADD_MONTHS, 1));
        send_cmd(set_cmd(2019, 1, 31));
        send_cmd(add_cmd(ACT_ADD_MONTHS, 1));
        send_cmd(set_cmd(2021, 12, 31));
        send_cmd(add_cmd(ACT_ADD_MONTHS, 1));
        send_cmd(add_cmd(ACT_ADD_MONTHS, 0));
        send_cmd(add_cmd(ACT_ADD_YEARS, 0));
        send_cmd(set_cmd(9999, 12, 31));
        send_cmd(add_cmd(ACT_ADD_DAYS, 1));
        send_cmd(add_cmd(ACT_ADD_MONTHS, 1));
        send_cmd(add_cmd(ACT_ADD_YEARS, 1));
        send_cmd(set_cmd(1600, 1, 1));
        send_cmd(add_cmd(ACT_ADD_DAYS, 65535));
        send_cmd(add_cmd(ACT_ADD_MONTHS, 65535));
        send_cmd(add_cmd(ACT_ADD_YEARS, 65535));
        wait_drained();

        // result side held off while requests keep coming, so the block backs up
        fork
            hold_results();
        join_none
        run_phase(0, 0, 30);

        run_phase(0, 0, 55);
        run_phase(51, 0, 55);
        run_phase(0, 51, 55);
        run_phase(10, 10, 55);

        repeat (50) @(posedge i_clk);
        if (tracker.faults == 0 && tracker.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
